/* rtl/core/swd_pkg.sv */
// ----------------------------------------------------------------------------
// swd_pkg: shared types and constants of the scroll wheel debounce unit
// Register indexes, configuration and result records, the push record that
// moves results from the core into the result queue, and the time compare.
// ----------------------------------------------------------------------------
package swd_pkg;

  // Result queue: up to two slots are written at once, one slot is read per cycle while out_ch is ready.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    REG_UP_MASK         = 3'd0,
    REG_DOWN_MASK       = 3'd1,
    REG_PRESS_MASK      = 3'd2,
    REG_PRESS_KIND      = 3'd3,
    REG_PRESS_CANCEL    = 3'd4,
    REG_BOUNCE_WINDOW   = 3'd5,
    REG_BOUNCE_LIMIT    = 3'd6,
    REG_PRESS_MUTE      = 3'd7
  } swd_reg_t;

  typedef struct packed {
    logic [31:0] up_mask;
    logic [31:0] down_mask;
    logic [31:0] press_mask;
    logic [3:0]  press_kind;
    logic [31:0] press_cancel_window;
    logic [31:0] bounce_window;
    logic [31:0] bounce_limit;
    logic [31:0] press_after_scroll_mute;
  } swd_cfg_t;

  typedef struct packed {
    logic        action;
    logic [3:0]  message_kind;
    logic [31:0] message_data;
    logic [31:0] message_time;
  } swd_item_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [31:0] result_data;
    logic [31:0] result_time;
    logic        last_of_run;
  } swd_result_t;

  // Results produced by one item, in order; count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0]  count;
    swd_result_t first;
    swd_result_t second;
  } swd_push_t;

  // True once time t has reached base + win, with the sum kept in 33 bits.
  function automatic logic swd_reached(logic [31:0] base, logic [31:0] win,
                                       logic [31:0] t);
    return {1'b0, t} >= ({1'b0, base} + {1'b0, win});
  endfunction

endpackage

/* rtl/core/swd_in_if.sv */
// ----------------------------------------------------------------------------
// swd_in_if: input message channel
// Valid/ready channel that carries one time-stamped message or time tick.
// ----------------------------------------------------------------------------
interface swd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  message_kind;
  logic [31:0] message_data;
  logic [31:0] message_time;

  modport source (output valid, action, message_kind, message_data, message_time,
                  input ready);
  modport sink (input valid, action, message_kind, message_data, message_time,
                output ready);
endinterface

/* rtl/core/swd_out_if.sv */
// ----------------------------------------------------------------------------
// swd_out_if: result message channel
// Valid/ready channel that carries one emitted message.
// ----------------------------------------------------------------------------
interface swd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_kind;
  logic [31:0] result_data;
  logic [31:0] result_time;
  logic        last_of_run;

  modport source (output valid, result_kind, result_data, result_time, last_of_run,
                  input ready);
  modport sink (input valid, result_kind, result_data, result_time, last_of_run,
                output ready);
endinterface

/* rtl/core/swd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// swd_cfg_regs: configuration register file
// Eight write-only registers with their reset values.
// ----------------------------------------------------------------------------
module swd_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output swd_pkg::swd_cfg_t  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_mask                 <= 32'd1;
      cfg.down_mask               <= 32'd2;
      cfg.press_mask              <= 32'd4;
      cfg.press_kind              <= 4'd0;
      cfg.press_cancel_window     <= 32'd100;
      cfg.bounce_window           <= 32'd50;
      cfg.bounce_limit            <= 32'd200;
      cfg.press_after_scroll_mute <= 32'd100;
    end else if (cfg_write_en) begin
      unique case (swd_pkg::swd_reg_t'(cfg_index))
        swd_pkg::REG_UP_MASK:       cfg.up_mask                 <= cfg_data;
        swd_pkg::REG_DOWN_MASK:     cfg.down_mask               <= cfg_data;
        swd_pkg::REG_PRESS_MASK:    cfg.press_mask              <= cfg_data;
        swd_pkg::REG_PRESS_KIND:    cfg.press_kind              <= cfg_data[3:0];
        swd_pkg::REG_PRESS_CANCEL:  cfg.press_cancel_window     <= cfg_data;
        swd_pkg::REG_BOUNCE_WINDOW: cfg.bounce_window           <= cfg_data;
        swd_pkg::REG_BOUNCE_LIMIT:  cfg.bounce_limit            <= cfg_data;
        swd_pkg::REG_PRESS_MUTE:    cfg.press_after_scroll_mute <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/swd_core.sv */
// ----------------------------------------------------------------------------
// swd_core: input register, debounce state and single-pass step logic
// Holds one input item, and when the result queue has room for two results
// it applies the item to the debounce state and pushes its results.
// ----------------------------------------------------------------------------
module swd_core (
  input  logic               clk,
  input  logic               rst,
  input  swd_pkg::swd_cfg_t  cfg,
  swd_in_if.sink             in_ch,
  input  logic               space_ok,
  output swd_pkg::swd_push_t push
);

  typedef struct packed {
    logic [31:0] press_last_time;
    logic        press_ready;
    logic [31:0] scroll_first_time;
    logic [31:0] scroll_last_time;
    logic [4:0]  scroll_balance;
    logic        scroll_open;
    logic [3:0]  scroll_start_kind;
    logic        scroll_had_press;
  } state_t;

  typedef struct packed {
    state_t               st;
    logic                 emit;
    swd_pkg::swd_result_t res;
  } step_t;

  logic                item_valid;
  swd_pkg::swd_item_t  item;
  state_t              state;
  state_t              state_next;
  logic                fire;
  step_t               step_a;
  step_t               step_b;

  function automatic logic out_of_band(state_t s);
    return ($signed(s.scroll_balance) < -2) || ($signed(s.scroll_balance) > 2);
  endfunction

  function automatic logic timed_out(state_t s, swd_pkg::swd_cfg_t c, logic [31:0] t);
    return swd_pkg::swd_reached(s.scroll_last_time, c.bounce_window, t)
        || swd_pkg::swd_reached(s.scroll_first_time, c.bounce_limit, t);
  endfunction

  function automatic logic due_at(state_t s, swd_pkg::swd_cfg_t c, logic [31:0] t);
    return s.scroll_open
        && (((s.scroll_balance != 5'd0)
             && swd_pkg::swd_reached(s.scroll_last_time, c.bounce_window, t))
            || out_of_band(s)
            || swd_pkg::swd_reached(s.scroll_first_time, c.bounce_limit, t));
  endfunction

  function automatic logic forwards(swd_pkg::swd_cfg_t c, logic [3:0] kind,
                                    logic [31:0] data);
    return (kind != c.press_kind)
        || ((data & ~(c.up_mask | c.down_mask | c.press_mask)) != 32'd0);
  endfunction

  // Balance plus a step of -1, 0 or +1, held within -15..15.
  function automatic logic [4:0] add_balance(logic [4:0] bal, logic [1:0] dlt);
    logic signed [5:0] b;
    b = $signed({bal[4], bal}) + $signed({{4{dlt[1]}}, dlt});
    if (b > 6'sd15) b = 6'sd15;
    if (b < -6'sd15) b = -6'sd15;
    return b[4:0];
  endfunction

  function automatic state_t press_receive(state_t s, swd_pkg::swd_cfg_t c,
                                           logic [31:0] data, logic [31:0] t);
    state_t r;
    r = s;
    if ((data & c.press_mask) != 32'd0) begin
      if (swd_pkg::swd_reached(s.press_last_time, c.press_cancel_window, t)) begin
        r.press_ready = 1'b1;
      end
      r.press_last_time = t;
    end
    return r;
  endfunction

  // Closes the pending scroll and emits its majority direction, if any.
  function automatic step_t close_scroll(state_t s, swd_pkg::swd_cfg_t c);
    step_t       r;
    logic [31:0] d;
    r.st   = s;
    r.emit = 1'b0;
    r.res  = '0;
    if ($signed(s.scroll_balance) > 0) begin
      d = c.up_mask;
    end else if ($signed(s.scroll_balance) < 0) begin
      d = c.down_mask;
    end else begin
      d = 32'd0;
    end
    r.st.scroll_open = 1'b0;
    if (d == 32'd0) begin
      r.st.press_ready = 1'b0;
    end else begin
      if (s.press_ready) begin
        d = d | c.press_mask;
        r.st.press_ready      = 1'b0;
        r.st.scroll_had_press = 1'b1;
      end
      r.emit = 1'b1;
      r.res  = '{s.scroll_start_kind, d, s.scroll_first_time, 1'b0};
    end
    return r;
  endfunction

  // Handles a message as if no scroll were pending.
  function automatic step_t fresh(state_t s, swd_pkg::swd_cfg_t c, logic [3:0] kind,
                                  logic [31:0] data, logic [31:0] t);
    step_t      r;
    logic       up;
    logic       down;
    logic       new_scroll;
    logic [1:0] dlt;
    r.st   = s;
    r.emit = 1'b0;
    r.res  = '0;
    up   = (data & c.up_mask) != 32'd0;
    down = (data & c.down_mask) != 32'd0;
    dlt  = (up && !down) ? 2'b01 : ((down && !up) ? 2'b11 : 2'b00);
    new_scroll = swd_pkg::swd_reached(s.scroll_last_time, c.bounce_window, t)
              || swd_pkg::swd_reached(s.scroll_first_time, c.bounce_limit, t);
    if (forwards(c, kind, data)) begin
      r.emit = 1'b1;
      r.res  = '{kind, data, t, 1'b0};
    end else if ((up || down) && new_scroll) begin
      r.st.scroll_last_time  = t;
      r.st.scroll_first_time = t;
      r.st.scroll_balance    = {{3{dlt[1]}}, dlt};
      r.st.scroll_open       = 1'b1;
      r.st.scroll_start_kind = kind;
      r.st.press_ready       = 1'b0;
      r.st.press_last_time   = 32'd0;
      r.st = press_receive(r.st, c, data, t);
      if (due_at(r.st, c, t)) begin
        r = close_scroll(r.st, c);
      end
    end else begin
      if (up || down) begin
        r.st.scroll_last_time = t;
        r.st.scroll_balance   = add_balance(s.scroll_balance, dlt);
      end
      r.st = press_receive(r.st, c, data, t);
      if (!(r.st.scroll_had_press
            && !swd_pkg::swd_reached(r.st.scroll_last_time,
                                     c.press_after_scroll_mute, t))
          && r.st.press_ready) begin
        r.st.press_ready = 1'b0;
        r.emit = 1'b1;
        r.res  = '{kind, c.press_mask, t, 1'b0};
      end
    end
    return r;
  endfunction

  assign fire         = item_valid && space_ok;
  assign in_ch.ready  = !item_valid || space_ok;

  // Step A is the close of a pending scroll, step B the message itself.
  always_comb begin
    state_t     upd;
    logic       up;
    logic       down;
    logic [1:0] dlt;
    step_a.st   = state;
    step_a.emit = 1'b0;
    step_a.res  = '0;
    step_b      = step_a;
    upd  = state;
    up   = (item.message_data & cfg.up_mask) != 32'd0;
    down = (item.message_data & cfg.down_mask) != 32'd0;
    dlt  = (up && !down) ? 2'b01 : ((down && !up) ? 2'b11 : 2'b00);
    if (item.action) begin
      if (state.scroll_open
          && (timed_out(state, cfg, item.message_time) || out_of_band(state))) begin
        step_a = close_scroll(state, cfg);
      end
      step_b.st = step_a.st;
    end else if (!state.scroll_open) begin
      step_b = fresh(state, cfg, item.message_kind, item.message_data,
                     item.message_time);
    end else if (forwards(cfg, item.message_kind, item.message_data)
                 || timed_out(state, cfg, item.message_time)
                 || out_of_band(state)) begin
      step_a = close_scroll(state, cfg);
      step_b = fresh(step_a.st, cfg, item.message_kind, item.message_data,
                     item.message_time);
    end else begin
      if (up || down) begin
        upd.scroll_balance   = add_balance(state.scroll_balance, dlt);
        upd.scroll_last_time = item.message_time;
      end
      upd = press_receive(upd, cfg, item.message_data, item.message_time);
      step_a.st = upd;
      if (due_at(upd, cfg, item.message_time)) begin
        step_a = close_scroll(upd, cfg);
      end
      step_b.st = step_a.st;
    end
  end

  always_comb begin
    state_next  = step_b.st;
    push.count  = {1'b0, step_a.emit} + {1'b0, step_b.emit};
    push.first  = step_a.emit ? step_a.res : step_b.res;
    push.second = step_b.res;
    push.first.last_of_run  = !(step_a.emit && step_b.emit);
    push.second.last_of_run = 1'b1;
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      state      <= '0;
    end else begin
      if (in_ch.ready) begin
        item_valid <= in_ch.valid;
      end
      if (fire) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item <= '{in_ch.action, in_ch.message_kind, in_ch.message_data,
                in_ch.message_time};
    end
  end

endmodule

/* rtl/core/swd_out_queue.sv */
// ----------------------------------------------------------------------------
// swd_out_queue: result queue
// Small queue that takes up to two results per cycle and hands out one per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module swd_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  swd_pkg::swd_push_t  push,
  output logic                space_ok,
  swd_out_if.source           out_ch
);

  localparam int unsigned Aw = swd_pkg::QueueAw;

  swd_pkg::swd_result_t entries [swd_pkg::QueueDepth];
  logic [Aw-1:0]        wr_ptr;
  logic [Aw-1:0]        rd_ptr;
  logic [Aw:0]          count;
  logic                 pop;
  logic [Aw-1:0]        wr_ptr_plus1;

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = count != '0;
  assign space_ok     = count <= (Aw + 1)'(swd_pkg::QueueDepth - 2);
  assign wr_ptr_plus1 = wr_ptr + Aw'(1);

  assign out_ch.result_kind = entries[rd_ptr].result_kind;
  assign out_ch.result_data = entries[rd_ptr].result_data;
  assign out_ch.result_time = entries[rd_ptr].result_time;
  assign out_ch.last_of_run = entries[rd_ptr].last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Aw'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + Aw'(1);
      end
      count <= count + (Aw + 1)'(push.count) - (Aw + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

endmodule

/* rtl/core/scroll_wheel_debounce_unit.sv */
// ----------------------------------------------------------------------------
// scroll_wheel_debounce_unit: scroll wheel and wheel press debouncer
// Top level: configuration registers, step core and result queue.
// ----------------------------------------------------------------------------
// The unit takes time-stamped input messages and time ticks on in_ch and
// emits debounced messages on out_ch. Messages of another kind, or carrying
// bits outside the up, down and press masks, pass through unchanged. Scroll
// pulses open a pending scroll whose up-minus-down balance is counted; the
// scroll closes on a boundary message, on a tick past its window or limit, or
// when the balance leaves -2..2, and then emits the majority direction, with
// the press bit added when a new press was seen during the scroll. A lone
// press is emitted at most once per cancel window. One item is accepted per
// clock cycle while the input register is empty or the result queue has
// room for two results: it lands in the input register, its whole step is
// evaluated combinationally from that register, and its results are written
// into a four-entry result queue, whose registered count drives out_ch valid.
// An item yields zero, one or two results; the result queue drains one
// result per cycle while out_ch is ready, so a stream of items that each
// give two results is paced by it; a stalled out_ch holds the input back once
// the queue cannot take two more results. The final result of an item has
// last_of_run set. Configuration registers are written through cfg_write_en,
// cfg_index and cfg_data, and are to be written only while the unit is idle.
// ----------------------------------------------------------------------------
module scroll_wheel_debounce_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  swd_in_if.sink      in_ch,
  swd_out_if.source   out_ch
);

  swd_pkg::swd_cfg_t  cfg;
  swd_pkg::swd_push_t push;
  logic               space_ok;

  // Register file with the documented reset values.
  swd_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  // Input register, debounce state and the combinational step logic.
  swd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .space_ok (space_ok),
    .push     (push)
  );

  // Result queue that separates the step logic from out_ch back-pressure.
  swd_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule
